### sv/rasm_pkg.sv
// shared types, constants and blink phase helpers for the rider alert block
`timescale 1ns / 1ps

package rasm_pkg;

    typedef enum logic [1:0] {
        MODE_OK     = 2'd0,
        MODE_DROWSY = 2'd1,
        MODE_CRASH  = 2'd2,
        MODE_PANIC  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_PITCH_LOW     = 3'd0,
        REG_PITCH_HIGH    = 3'd1,
        REG_CRASH_ACCEL   = 3'd2,
        REG_CRASH_RATE    = 3'd3,
        REG_DROWSY_CONFIRM = 3'd4,
        REG_ALERT_HOLD    = 3'd5,
        REG_BUTTON_GUARD  = 3'd6,
        REG_BATTERY_LOW   = 3'd7
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [13:0] RST_PITCH_LOW      = 14'd2500;
    localparam logic [13:0] RST_PITCH_HIGH     = 14'd6000;
    localparam logic [15:0] RST_CRASH_ACCEL    = 16'd2500;
    localparam logic [15:0] RST_CRASH_RATE     = 16'd300;
    localparam logic [15:0] RST_DROWSY_CONFIRM = 16'd1500;
    localparam logic [15:0] RST_ALERT_HOLD     = 16'd3000;
    localparam logic [15:0] RST_BUTTON_GUARD   = 16'd300;
    localparam logic [6:0]  RST_BATTERY_LOW    = 7'd20;

    localparam logic [10:0] HZ_DROWSY = 11'd880;
    localparam logic [10:0] HZ_ALARM  = 11'd1500;

    // floor(x / 125) = (x * PHASE_RECIP) >> PHASE_SHIFT, exact for 28-bit x
    localparam logic [28:0] PHASE_RECIP = 29'd274877907;
    localparam int          PHASE_SHIFT = 35;
    localparam logic [6:0]  PHASE_DIV   = 7'd125;

    typedef struct packed {
        logic [13:0] pitch_low_cdeg;
        logic [13:0] pitch_high_cdeg;
        logic [15:0] crash_accel_mg;
        logic [15:0] crash_rate_dps;
        logic [15:0] drowsy_wait_ms;
        logic [15:0] alert_hold_ms;
        logic [15:0] button_guard_ms;
        logic [6:0]  low_batt_pct;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [13:0] pitch_cdeg;
        logic [15:0] accel_mg;
        logic [15:0] rate_dps;
        logic        button_level;
        logic [6:0]  battery_pct;
    } sample_t;

    typedef struct packed {
        logic drowsy_on;
        logic alarm_buzz;
        logic alarm_red;
        logic ok_blink;
    } phase_t;

    typedef struct packed {
        mode_t       mode_code;
        logic        alert_flag;
        logic        buzzer_on;
        logic [10:0] buzzer_hz;
        logic        vibrate_on;
        logic        red_led_on;
    } result_t;

    // blink flags from time mod 2000
    function automatic phase_t phase_flags(input logic [10:0] m2000);
        phase_t      p;
        logic [10:0] m1000;
        p = '0;
        m1000 = (m2000 >= 11'd1000) ? (m2000 - 11'd1000) : m2000;
        p.drowsy_on = (m1000 < 11'd300);
        p.ok_blink  = (m1000 < 11'd150);
        for (int k = 0; k < 5; k++)
        begin
            if (m2000 >= 11'(400 * k) && m2000 < 11'(400 * k + 200))
            begin
                p.alarm_buzz = 1'b1;
            end
        end
        for (int k = 0; k < 10; k++)
        begin
            if (m2000 >= 11'(200 * k) && m2000 < 11'(200 * k + 100))
            begin
                p.alarm_red = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

### sv/rasm_cfg.sv
// configuration register file with reset defaults
`timescale 1ns / 1ps

module rasm_cfg
    import rasm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_low_cdeg    <= RST_PITCH_LOW;
            cfg_reg.pitch_high_cdeg   <= RST_PITCH_HIGH;
            cfg_reg.crash_accel_mg    <= RST_CRASH_ACCEL;
            cfg_reg.crash_rate_dps    <= RST_CRASH_RATE;
            cfg_reg.drowsy_wait_ms    <= RST_DROWSY_CONFIRM;
            cfg_reg.alert_hold_ms     <= RST_ALERT_HOLD;
            cfg_reg.button_guard_ms   <= RST_BUTTON_GUARD;
            cfg_reg.low_batt_pct      <= RST_BATTERY_LOW;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PITCH_LOW:      cfg_reg.pitch_low_cdeg    <= cfg_data[13:0];
                REG_PITCH_HIGH:     cfg_reg.pitch_high_cdeg   <= cfg_data[13:0];
                REG_CRASH_ACCEL:    cfg_reg.crash_accel_mg    <= cfg_data;
                REG_CRASH_RATE:     cfg_reg.crash_rate_dps    <= cfg_data;
                REG_DROWSY_CONFIRM: cfg_reg.drowsy_wait_ms    <= cfg_data;
                REG_ALERT_HOLD:     cfg_reg.alert_hold_ms     <= cfg_data;
                REG_BUTTON_GUARD:   cfg_reg.button_guard_ms   <= cfg_data;
                REG_BATTERY_LOW:    cfg_reg.low_batt_pct      <= cfg_data[6:0];
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/rasm_phase.sv
// blink phase unit: time mod 2000 by reciprocal multiply, then pattern flags
`timescale 1ns / 1ps

module rasm_phase
    import rasm_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [31:0] now_ms,
    output phase_t      phase
);

    logic [56:0] prod;
    logic [21:0] quot_reg;
    logic [6:0]  xlo_reg;
    logic [3:0]  tlo_reg;
    logic [6:0]  qm;
    logic [6:0]  rem;

    // now / 16 divided by 125
    assign prod = 57'(now_ms[31:4]) * 57'(PHASE_RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= prod[56:PHASE_SHIFT];
            xlo_reg  <= now_ms[10:4];
            tlo_reg  <= now_ms[3:0];
        end
    end

    // remainder below 125 so seven low bits are enough
    assign qm    = quot_reg[6:0] * PHASE_DIV;
    assign rem   = xlo_reg - qm;
    assign phase = phase_flags({rem, tlo_reg});

endmodule

### sv/rasm_mode.sv
// alert mode state and per-sample output pattern
`timescale 1ns / 1ps

module rasm_mode
    import rasm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  sample_t smp,
    input  cfg_t    cfg,
    input  phase_t  phase,
    output result_t res
);

    mode_t       mode_reg, mode_next;
    logic        alert_on_reg, alert_on_next;
    logic [31:0] drowsy_since_reg, drowsy_since_next;
    logic [31:0] alert_since_reg, alert_since_next;
    logic [31:0] last_press_reg, last_press_next;

    logic        alarm_mode;
    logic        expire;
    mode_t       mode_kept;
    logic        alert_kept;
    logic        press;
    logic        crash;
    logic        in_window;
    logic [31:0] ds_start;

    always_comb
    begin
        alarm_mode = (mode_reg == MODE_CRASH) || (mode_reg == MODE_PANIC);
        expire = alert_on_reg && alarm_mode
                 && ((smp.now_ms - alert_since_reg) > 32'(cfg.alert_hold_ms));
        mode_kept  = expire ? MODE_OK : mode_reg;
        alert_kept = expire ? 1'b0 : alert_on_reg;
        press = !smp.button_level
                && ((smp.now_ms - last_press_reg) > 32'(cfg.button_guard_ms));
        crash = (smp.accel_mg > cfg.crash_accel_mg) || (smp.rate_dps > cfg.crash_rate_dps);
        in_window = (smp.pitch_cdeg > cfg.pitch_low_cdeg)
                    && (smp.pitch_cdeg < cfg.pitch_high_cdeg);
        ds_start = (drowsy_since_reg == 32'd0) ? smp.now_ms : drowsy_since_reg;

        mode_next         = mode_kept;
        alert_on_next     = alert_kept;
        drowsy_since_next = drowsy_since_reg;
        alert_since_next  = alert_since_reg;
        last_press_next   = last_press_reg;

        if (press)
        begin
            mode_next        = MODE_PANIC;
            alert_on_next    = 1'b1;
            alert_since_next = smp.now_ms;
            last_press_next  = smp.now_ms;
        end
        else if (crash)
        begin
            mode_next        = MODE_CRASH;
            alert_on_next    = 1'b1;
            alert_since_next = smp.now_ms;
        end
        else if (mode_kept == MODE_CRASH || mode_kept == MODE_PANIC)
        begin
            mode_next = mode_kept;
        end
        else if (in_window)
        begin
            drowsy_since_next = ds_start;
            if ((smp.now_ms - ds_start) > 32'(cfg.drowsy_wait_ms))
            begin
                mode_next        = MODE_DROWSY;
                alert_on_next    = 1'b1;
                alert_since_next = smp.now_ms;
            end
        end
        else
        begin
            drowsy_since_next = 32'd0;
            if (mode_kept == MODE_DROWSY)
            begin
                mode_next     = MODE_OK;
                alert_on_next = 1'b0;
            end
        end

        res = '0;
        res.mode_code  = mode_next;
        res.alert_flag = alert_on_next;
        case (mode_next)
            MODE_DROWSY:
            begin
                res.buzzer_on  = phase.drowsy_on;
                res.vibrate_on = phase.drowsy_on;
                res.red_led_on = 1'b1;
                res.buzzer_hz  = phase.drowsy_on ? HZ_DROWSY : 11'd0;
            end
            MODE_CRASH, MODE_PANIC:
            begin
                res.buzzer_on  = phase.alarm_buzz;
                res.vibrate_on = 1'b1;
                res.red_led_on = phase.alarm_red;
                res.buzzer_hz  = phase.alarm_buzz ? HZ_ALARM : 11'd0;
            end
            default:
            begin
                res.red_led_on = (smp.battery_pct <= cfg.low_batt_pct) && phase.ok_blink;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_OK;
            alert_on_reg     <= 1'b0;
            drowsy_since_reg <= 32'd0;
            alert_since_reg  <= 32'd0;
            last_press_reg   <= 32'd0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            alert_on_reg     <= alert_on_next;
            drowsy_since_reg <= drowsy_since_next;
            alert_since_reg  <= alert_since_next;
            last_press_reg   <= last_press_next;
        end
    end

    // an alert is active exactly when the mode is not ok
    a_alert_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        alert_on_reg == (mode_reg != MODE_OK))
        else $error("alert flag out of step with mode");

    // an accepted press records its time and enters panic
    a_press_panic: assert property (@(posedge clk) disable iff (!rst_n)
        step && press |=> mode_reg == MODE_PANIC && last_press_reg == $past(smp.now_ms))
        else $error("panic press not recorded");

endmodule

### sv/rider_alert_state_machine.sv
// top level: input stage, phase stage, mode update and result register
`timescale 1ns / 1ps

// Takes one sensor sample per transfer and returns one alert result per sample, in order.
// A sample passes three registers (input, phase multiply, result) before its result is offered
// on the output; a new sample can be taken every cycle unless the output stalls, set by the
// mode state update, which finishes one sample per cycle while m_tready or an empty result
// register allows. Bubbles in the pipeline let the input keep accepting while a result waits on
// the output. Configuration writes take effect at once and are meant to be done while no
// sample is in flight.

module rider_alert_state_machine
    import rasm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], pitch_cdeg[45:32], accel_mg[61:46], rate_dps[77:62],
    // button_level[78], battery_pct[85:79], zero pad[87:86]
    input  logic [87:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mode_code[1:0], alert_flag[2], buzzer_on[3], buzzer_hz[14:4],
    // vibrate_on[15], red_led_on[16], zero pad[23:17]
    output logic [23:0]            m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    phase_t  phase;
    result_t res;
    sample_t s_in;

    logic    s1_valid_reg, s2_valid_reg, out_valid_reg;
    sample_t s1_reg, s2_reg;
    result_t out_reg;
    logic    adv1, adv2, adv3;
    logic    step;

    assign s_in.now_ms       = s_tdata[31:0];
    assign s_in.pitch_cdeg   = s_tdata[45:32];
    assign s_in.accel_mg     = s_tdata[61:46];
    assign s_in.rate_dps     = s_tdata[77:62];
    assign s_in.button_level = s_tdata[78];
    assign s_in.battery_pct  = s_tdata[85:79];

    assign adv3     = !out_valid_reg || m_tready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1;
    assign step     = s2_valid_reg && adv3;

    rasm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rasm_phase u_phase (
        .clk    (clk),
        .load   (adv2),
        .now_ms (s1_reg.now_ms),
        .phase  (phase)
    );

    rasm_mode u_mode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .smp   (s2_reg),
        .cfg   (cfg),
        .phase (phase),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s_in;
        end
        if (adv2)
        begin
            s2_reg <= s1_reg;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.red_led_on, out_reg.vibrate_on, out_reg.buzzer_hz,
                       out_reg.buzzer_on, out_reg.alert_flag, out_reg.mode_code};

    // silent buzzer carries no tone
    a_tone_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.buzzer_on |-> out_reg.buzzer_hz == 11'd0)
        else $error("tone present with buzzer off");

    // an empty input stage always takes a transfer
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule
